// ----- src/iirdf_pkg.sv -----
// ----------------------------------------------------------------------------
// iirdf_pkg
// Shared types and fixed-point constants for the direct-form-I IIR filter.
// ----------------------------------------------------------------------------
package iirdf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = 40;
  localparam int FRAC_BITS  = 14;
  localparam int CNT_REG_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int FUNC_W     = 2;
  localparam int COEF_IDX_W = 3;

  localparam logic signed [ACC_W-1:0]    ROUND_HALF = ACC_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_LOAD_B = 2'd1,
    FUNC_LOAD_A = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_B_COUNT = 2'd0,
    CFG_A_COUNT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic load_item;
    logic hist_we;
    logic coef_we_b;
    logic coef_we_a;
    logic item_ok;
    logic tap_en;
    logic tap_fb;
    logic clr_hist;
    logic commit;
  } iirdf_cmd_t;

  typedef struct packed {
    logic out_free;
  } iirdf_status_t;

endpackage

// ----- src/iirdf_ctrl.sv -----
// ----------------------------------------------------------------------------
// iirdf_ctrl
// Sequencer for the IIR filter: holds the tap counts, accepts requests and
// steps the shared multiply-accumulate through the active taps.
// ----------------------------------------------------------------------------
module iirdf_ctrl #(
  parameter int MAX_TAPS = 8,
  localparam int IDX_W = $clog2(MAX_TAPS),
  localparam int CNT_W = $clog2(MAX_TAPS + 1)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [iirdf_pkg::FUNC_W-1:0]          func_i,
  input  logic [iirdf_pkg::COEF_IDX_W-1:0]      coef_index_i,
  input  logic                                  cfg_valid_i,
  input  logic [iirdf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [iirdf_pkg::CNT_REG_W-1:0]       cfg_data_i,
  output iirdf_pkg::iirdf_cmd_t                 cmd_o,
  output logic [IDX_W-1:0]                      tap_idx_o,
  input  iirdf_pkg::iirdf_status_t              status_i
);
  import iirdf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FWD   = 5'b00010,
    S_FB    = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  logic [IDX_W-1:0]       cnt_q, cnt_d;
  logic [CNT_REG_W-1:0]   b_count_q, a_count_q;
  logic [CNT_W-1:0]       nb_eff, na_eff;
  logic                   idx_ok_b, idx_ok_a, last_b, last_a;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_REG_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (int'(c) > MAX_TAPS) begin
      r = CNT_W'(MAX_TAPS);
    end else begin
      r = CNT_W'(c);
    end
    return r;
  endfunction

  assign nb_eff   = eff_count(b_count_q);
  assign na_eff   = eff_count(a_count_q);
  assign idx_ok_b = int'(coef_index_i) < int'(nb_eff);
  assign idx_ok_a = int'(coef_index_i) < int'(na_eff);
  assign last_b   = (CNT_W'(cnt_q) + CNT_W'(1)) == nb_eff;
  assign last_a   = (CNT_W'(cnt_q) + CNT_W'(1)) == na_eff;

  assign tap_idx_o  = cnt_q;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DONE;
          case (func_i)
            FUNC_SAMPLE: begin
              cmd_o.hist_we = 1'b1;
              cmd_o.item_ok = 1'b1;
              cnt_d         = '0;
              state_d       = S_FWD;
            end
            FUNC_LOAD_B: begin
              cmd_o.coef_we_b = idx_ok_b;
              cmd_o.item_ok   = idx_ok_b;
            end
            FUNC_LOAD_A: begin
              cmd_o.coef_we_a = idx_ok_a;
              cmd_o.item_ok   = idx_ok_a;
            end
            default: begin
              cmd_o.item_ok = 1'b0;
            end
          endcase
        end
      end
      S_FWD: begin
        cmd_o.tap_en = 1'b1;
        if (last_b) begin
          if (na_eff > CNT_W'(1)) begin
            cnt_d   = IDX_W'(1);
            state_d = S_FB;
          end else begin
            cnt_d   = '0;
            state_d = S_DRAIN;
          end
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end
      S_FB: begin
        cmd_o.tap_en = 1'b1;
        cmd_o.tap_fb = 1'b1;
        if (last_a) begin
          cnt_d   = '0;
          state_d = S_DRAIN;
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (cnt_q == IDX_W'(1)) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (cfg_valid_i && (cfg_index_i == CFG_B_COUNT || cfg_index_i == CFG_A_COUNT)) begin
      cmd_o.clr_hist = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      b_count_q <= CNT_REG_W'(1);
      a_count_q <= CNT_REG_W'(1);
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i && cfg_index_i == CFG_B_COUNT) begin
        b_count_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == CFG_A_COUNT) begin
        a_count_q <= cfg_data_i;
      end
    end
  end

endmodule

// ----- src/iirdf_dp.sv -----
// ----------------------------------------------------------------------------
// iirdf_dp
// Datapath of the IIR filter: sample and coefficient memories, the pipelined
// multiply-accumulate, rounding with saturation and the output register.
// ----------------------------------------------------------------------------
module iirdf_dp #(
  parameter int MAX_TAPS = 8,
  localparam int IDX_W = $clog2(MAX_TAPS),
  localparam int CNT_W = $clog2(MAX_TAPS + 1)
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  iirdf_pkg::iirdf_cmd_t                      cmd_i,
  input  logic [IDX_W-1:0]                           tap_idx_i,
  output iirdf_pkg::iirdf_status_t                   status_o,
  input  logic signed [iirdf_pkg::SAMPLE_W-1:0]      sample_in_i,
  input  logic [iirdf_pkg::COEF_IDX_W-1:0]           coef_index_i,
  input  logic signed [iirdf_pkg::COEF_W-1:0]        coef_value_i,
  input  logic                                       out_stall_i,
  output logic                                       out_valid_o,
  output logic signed [iirdf_pkg::SAMPLE_W-1:0]      sample_out_o,
  output logic                                       accepted_o
);
  import iirdf_pkg::*;

  localparam int SHF_W = ACC_W - FRAC_BITS + 1;

  logic signed [SAMPLE_W-1:0] in_hist  [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] out_hist [MAX_TAPS];
  logic signed [COEF_W-1:0]   coef_b   [MAX_TAPS];
  logic signed [COEF_W-1:0]   coef_a   [MAX_TAPS];
  logic [MAX_TAPS-1:0]        cb_vld_q, ca_vld_q;

  logic [IDX_W-1:0]           pos_q;
  logic [CNT_W-1:0]           fill_q;
  logic                       is_sample_q, ok_q;

  logic [IDX_W:0]             diff;
  logic [IDX_W-1:0]           rd_addr, wr_idx;
  logic                       rd_ok;

  logic                       s1_v_q, s1_fb_q, h_ok_q, c_ok_q;
  logic signed [SAMPLE_W-1:0] hist_q, op_h;
  logic signed [COEF_W-1:0]   coef_q, op_c;
  logic                       s2_v_q, s2_fb_q;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic signed [ACC_W-1:0]    acc_q;

  logic signed [ACC_W:0]      rnd;
  logic signed [SHF_W-1:0]    shf;
  logic signed [SAMPLE_W-1:0] y;

  logic                       out_valid_q, accepted_q;
  logic signed [SAMPLE_W-1:0] sample_out_q;

  assign wr_idx  = IDX_W'(coef_index_i);
  assign diff    = {1'b0, pos_q} - {1'b0, tap_idx_i};
  assign rd_addr = diff[IDX_W] ? IDX_W'(diff + (IDX_W + 1)'(MAX_TAPS)) : diff[IDX_W-1:0];
  assign rd_ok   = (CNT_W'(rd_addr) < fill_q) || (!cmd_i.tap_fb && rd_addr == pos_q);

  assign op_h   = h_ok_q ? hist_q : '0;
  assign op_c   = c_ok_q ? coef_q : '0;
  assign prod_d = op_h * op_c;

  assign rnd = (ACC_W + 1)'(acc_q) + (ACC_W + 1)'(ROUND_HALF);
  assign shf = signed'(rnd[ACC_W:FRAC_BITS]);

  always_comb begin
    if (shf > SHF_W'(SAMPLE_MAX)) begin
      y = SAMPLE_MAX;
    end else if (shf < SHF_W'(SAMPLE_MIN)) begin
      y = SAMPLE_MIN;
    end else begin
      y = shf[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hist_we) begin
      in_hist[pos_q] <= sample_in_i;
    end
    if (cmd_i.commit && is_sample_q) begin
      out_hist[pos_q] <= y;
    end
    if (cmd_i.coef_we_b) begin
      coef_b[wr_idx] <= coef_value_i;
    end
    if (cmd_i.coef_we_a) begin
      coef_a[wr_idx] <= coef_value_i;
    end
    if (cmd_i.tap_en) begin
      hist_q <= cmd_i.tap_fb ? out_hist[rd_addr] : in_hist[rd_addr];
      coef_q <= cmd_i.tap_fb ? coef_a[tap_idx_i] : coef_b[tap_idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tap_en) begin
      h_ok_q <= rd_ok;
      c_ok_q <= cmd_i.tap_fb ? ca_vld_q[tap_idx_i] : cb_vld_q[tap_idx_i];
    end
    if (cmd_i.load_item) begin
      is_sample_q <= cmd_i.hist_we;
      ok_q        <= cmd_i.item_ok;
    end
    prod_q <= prod_d;
    if (cmd_i.load_item) begin
      acc_q <= '0;
    end else if (s2_v_q) begin
      acc_q <= s2_fb_q ? acc_q - ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
    end
    if (cmd_i.commit) begin
      sample_out_q <= is_sample_q ? y : '0;
      accepted_q   <= ok_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cb_vld_q    <= '0;
      ca_vld_q    <= '0;
      pos_q       <= '0;
      fill_q      <= '0;
      s1_v_q      <= 1'b0;
      s1_fb_q     <= 1'b0;
      s2_v_q      <= 1'b0;
      s2_fb_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.coef_we_b) begin
        cb_vld_q[wr_idx] <= 1'b1;
      end
      if (cmd_i.coef_we_a) begin
        ca_vld_q[wr_idx] <= 1'b1;
      end
      if (cmd_i.clr_hist) begin
        pos_q  <= '0;
        fill_q <= '0;
      end else if (cmd_i.commit && is_sample_q) begin
        pos_q <= (pos_q == IDX_W'(MAX_TAPS - 1)) ? '0 : pos_q + IDX_W'(1);
        if (fill_q != CNT_W'(MAX_TAPS)) begin
          fill_q <= fill_q + CNT_W'(1);
        end
      end
      s1_v_q  <= cmd_i.tap_en;
      s1_fb_q <= cmd_i.tap_fb;
      s2_v_q  <= s1_v_q;
      s2_fb_q <= s1_fb_q;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign sample_out_o      = sample_out_q;
  assign accepted_o        = accepted_q;

endmodule

// ----- src/iir_direct_form_filter.sv -----
// ----------------------------------------------------------------------------
// iir_direct_form_filter
// A sample request steps the single multiply-accumulate through the active
// taps, one tap per cycle; the tap counts are read with zero as one and values
// above MAX_TAPS as MAX_TAPS. The result register lets the next request enter
// while a result is still stalled at the output.
// Reset clears histories, coefficients and sets both tap counts to one.
// ----------------------------------------------------------------------------
module iir_direct_form_filter #(
  parameter int MAX_TAPS = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [iirdf_pkg::FUNC_W-1:0]          func_i,
  input  logic signed [iirdf_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic [iirdf_pkg::COEF_IDX_W-1:0]      coef_index_i,
  input  logic signed [iirdf_pkg::COEF_W-1:0]   coef_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [iirdf_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic                                  accepted_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [iirdf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [iirdf_pkg::CNT_REG_W-1:0]       cfg_data_i
);
  import iirdf_pkg::*;

  localparam int IDX_W = $clog2(MAX_TAPS);

  iirdf_cmd_t       cmd;
  iirdf_status_t    status;
  logic [IDX_W-1:0] tap_idx;

  assign cfg_ready_o = 1'b1;

  iirdf_ctrl #(
    .MAX_TAPS (MAX_TAPS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .coef_index_i (coef_index_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_o        (cmd),
    .tap_idx_o    (tap_idx),
    .status_i     (status)
  );

  iirdf_dp #(
    .MAX_TAPS (MAX_TAPS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .tap_idx_i    (tap_idx),
    .status_o     (status),
    .sample_in_i  (sample_in_i),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .sample_out_o (sample_out_o),
    .accepted_o   (accepted_o)
  );

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("Request accepted but the block did not turn busy.");

  a_reject_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !accepted_o) |-> (sample_out_o == '0))
    else $error("Rejected request returned a nonzero sample.");

  a_result_follows_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("Result appeared without a request in progress.");

  a_tap_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.tap_en |-> (in_stall_o && !cmd.commit))
    else $error("Tap issued outside a sample computation.");

endmodule

// ----- tb/iir_direct_form_filter_tb.sv -----
// ----------------------------------------------------------------------------
// iir_direct_form_filter_tb
// Self-checking testbench for the fixed-point direct-form-I IIR filter.
// A queue-fed driver presents sample and coefficient-load requests while a
// monitor predicts every response from its own model of the histories,
// coefficient tables and tap counts, and compares each response field by
// field. Tap counts are reprogrammed between phases while the filter is idle,
// and both sides idle in random bursts except in the last phase.
// ----------------------------------------------------------------------------
module iir_direct_form_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iirdf_pkg::*;

  localparam int MAX_TAPS       = 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 2 * (2 * MAX_TAPS + 3);
  localparam int RANDOM_PHASES  = 9;
  localparam int MIXED_PER_PHASE = 30;

  localparam logic [FUNC_W-1:0]    FUNC_UNUSED     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]            func;
    logic signed [SAMPLE_W-1:0]   sample;
    logic [COEF_IDX_W-1:0]        index;
    logic signed [COEF_W-1:0]     value;
  } filt_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       accepted;
  } filt_resp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [FUNC_W-1:0]           func = '0;
  logic signed [SAMPLE_W-1:0]  sample_in = '0;
  logic [COEF_IDX_W-1:0]       coef_index = '0;
  logic signed [COEF_W-1:0]    coef_value = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0]  sample_out;
  logic                        accepted;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CNT_REG_W-1:0]        cfg_data = '0;

  iir_direct_form_filter #(
    .MAX_TAPS(MAX_TAPS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .func_i      (func),
    .sample_in_i (sample_in),
    .coef_index_i(coef_index),
    .coef_value_i(coef_value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .sample_out_o(sample_out),
    .accepted_o  (accepted),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Filter model state.
  logic [CNT_REG_W-1:0]       b_count_q = 4'd1;
  logic [CNT_REG_W-1:0]       a_count_q = 4'd1;
  logic signed [SAMPLE_W-1:0] x_hist [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] y_hist [MAX_TAPS];
  logic [2:0]                 x_pos = '0;
  logic [2:0]                 y_pos = '0;
  logic signed [COEF_W-1:0]   b_coef [MAX_TAPS];
  logic signed [COEF_W-1:0]   a_coef [MAX_TAPS];

  filt_req_t  pending_requests [$];
  filt_resp_t expected_responses [$];

  bit req_fired = 1'b0;
  bit cfg_fired = 1'b0;
  bit resp_fired = 1'b0;
  bit calm = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int fail_count = 0;
  int samples_filtered = 0;
  int loads_taken = 0;
  int loads_refused = 0;
  int unused_requests = 0;
  int count_settings = 0;

  filt_req_t  next_req;
  filt_req_t  seen_req;
  filt_resp_t want_resp;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < MAX_TAPS; i++) begin
      x_hist[i] = '0;
      y_hist[i] = '0;
      b_coef[i] = '0;
      a_coef[i] = '0;
    end
  end

  function automatic int unsigned tap_limit(logic [CNT_REG_W-1:0] count);
    if (count == 0) return 1;
    if (count > MAX_TAPS) return MAX_TAPS;
    return 32'(count);
  endfunction

  task automatic filter_predict(input filt_req_t req, output filt_resp_t resp);
    int unsigned nb;
    int unsigned na;
    int unsigned i;
    longint acc;
    longint q;
    logic [2:0] k;
    resp = '0;
    nb = tap_limit(b_count_q);
    na = tap_limit(a_count_q);
    case (req.func)
      FUNC_SAMPLE: begin
        x_hist[x_pos] = req.sample;
        acc = 0;
        for (i = 0; i < nb; i++) begin
          k = x_pos - 3'(i);
          acc += longint'(b_coef[i]) * longint'(x_hist[k]);
        end
        for (i = 1; i < na; i++) begin
          k = y_pos - 3'(i);
          acc -= longint'(a_coef[i]) * longint'(y_hist[k]);
        end
        q = (acc + longint'(ROUND_HALF)) >>> FRAC_BITS;
        if (q > longint'(SAMPLE_MAX)) q = longint'(SAMPLE_MAX);
        if (q < longint'(SAMPLE_MIN)) q = longint'(SAMPLE_MIN);
        y_hist[y_pos] = SAMPLE_W'(q);
        x_pos = x_pos + 3'd1;
        y_pos = y_pos + 3'd1;
        resp.sample_out = SAMPLE_W'(q);
        resp.accepted = 1'b1;
      end
      FUNC_LOAD_B: begin
        if (req.index < tap_limit(b_count_q)) begin
          b_coef[req.index] = req.value;
          resp.accepted = 1'b1;
        end
      end
      FUNC_LOAD_A: begin
        if (req.index < tap_limit(a_count_q)) begin
          a_coef[req.index] = req.value;
          resp.accepted = 1'b1;
        end
      end
      default: begin
      end
    endcase
  endtask

  // Driver: presents the next queued request once the current one is taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || req_fired) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
          in_valid <= 1'b0;
          gap_left = $urandom_range(1, 9) - 1;
        end else if (pending_requests.size() > 0) begin
          next_req = pending_requests.pop_front();
          in_valid   <= 1'b1;
          func       <= next_req.func;
          sample_in  <= next_req.sample;
          coef_index <= next_req.index;
          coef_value <= next_req.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(1, 9) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: predicts on every accepted request and checks every response.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      req_fired  = in_valid && !in_stall;
      cfg_fired  = cfg_valid && cfg_ready;
      resp_fired = out_valid && !out_stall;

      if (cfg_fired && (cfg_index == CFG_B_COUNT || cfg_index == CFG_A_COUNT)) begin
        if (cfg_index == CFG_B_COUNT) begin
          b_count_q = cfg_data;
        end else begin
          a_count_q = cfg_data;
        end
        for (int i = 0; i < MAX_TAPS; i++) begin
          x_hist[i] = '0;
          y_hist[i] = '0;
        end
        x_pos = '0;
        y_pos = '0;
      end

      if (req_fired) begin
        seen_req = '{func: func, sample: sample_in, index: coef_index, value: coef_value};
        filter_predict(seen_req, want_resp);
        expected_responses.push_back(want_resp);
        if (seen_req.func == FUNC_SAMPLE) begin
          samples_filtered++;
        end else if (seen_req.func == FUNC_UNUSED) begin
          unused_requests++;
        end else if (want_resp.accepted) begin
          loads_taken++;
        end else begin
          loads_refused++;
        end
      end

      if (resp_fired) begin
        if (expected_responses.size() == 0) begin
          $display("%0t: response with none expected: sample_out %0d accepted %0b",
                   $time, sample_out, accepted);
          fail_count++;
        end else begin
          want_resp = expected_responses.pop_front();
          if (sample_out !== want_resp.sample_out) begin
            $display("%0t: sample_out expected %0d actual %0d",
                     $time, want_resp.sample_out, sample_out);
            fail_count++;
          end
          if (accepted !== want_resp.accepted) begin
            $display("%0t: accepted expected %0b actual %0b",
                     $time, want_resp.accepted, accepted);
            fail_count++;
          end
        end
      end

      if (req_fired || cfg_fired || resp_fired) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic queue_request(logic [FUNC_W-1:0] f, logic signed [SAMPLE_W-1:0] x,
                               logic [COEF_IDX_W-1:0] k, logic signed [COEF_W-1:0] c);
    pending_requests.push_back('{func: f, sample: x, index: k, value: c});
  endtask

  function automatic logic signed [COEF_W-1:0] pick_coef(int spread);
    if ($urandom_range(0, 4) == 0) return COEF_W'($urandom);
    return COEF_W'(int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3, 4, 5: return SAMPLE_W'($urandom);
      default: return SAMPLE_W'(int'($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || expected_responses.size() != 0 || in_valid);
  endtask

  task automatic write_counts(logic [CNT_REG_W-1:0] b_val, logic [CNT_REG_W-1:0] a_val,
                              bit spare);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_B_COUNT;
    cfg_data  <= b_val;
    do @(negedge clk_i); while (!cfg_fired);
    cfg_index <= CFG_A_COUNT;
    cfg_data  <= a_val;
    do @(negedge clk_i); while (!cfg_fired);
    if (spare) begin
      cfg_index <= CFG_SPARE_FIRST + CFG_IDX_W'($urandom_range(0, 1));
      cfg_data  <= CNT_REG_W'($urandom);
      do @(negedge clk_i); while (!cfg_fired);
    end
    cfg_valid <= 1'b0;
    count_settings++;
  endtask

  initial begin
    logic [CNT_REG_W-1:0] b_set;
    logic [CNT_REG_W-1:0] a_set;
    int pick;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset counts: one forward tap and no feedback.
    queue_request(FUNC_LOAD_B, 16'sd0, 3'd0, 18'sd16384);
    queue_request(FUNC_SAMPLE, SAMPLE_MAX, 3'd5, 18'sd0);
    queue_request(FUNC_SAMPLE, SAMPLE_MIN, 3'd2, 18'sd0);
    queue_request(FUNC_LOAD_B, 16'sd0, 3'd1, 18'sd5);
    queue_request(FUNC_LOAD_A, 16'sd0, 3'd0, 18'sd131071);
    queue_request(FUNC_LOAD_A, 16'sd0, 3'd1, 18'sd100);
    queue_request(FUNC_UNUSED, 16'sh7FFF, 3'd7, -18'sd1);
    queue_request(FUNC_LOAD_B, 16'sd0, 3'd0, 18'sd131071);
    queue_request(FUNC_SAMPLE, SAMPLE_MAX, 3'd0, 18'sd0);
    queue_request(FUNC_SAMPLE, SAMPLE_MIN, 3'd0, 18'sd0);
    queue_request(FUNC_LOAD_B, 16'sd0, 3'd0, -18'sd131072);
    queue_request(FUNC_SAMPLE, 16'sd1, 3'd0, 18'sd0);
    queue_request(FUNC_SAMPLE, -16'sd1, 3'd0, 18'sd0);
    queue_request(FUNC_LOAD_B, 16'sd0, 3'd0, 18'sd8192);
    queue_request(FUNC_SAMPLE, 16'sd1, 3'd0, 18'sd0);
    queue_request(FUNC_SAMPLE, -16'sd1, 3'd0, 18'sd0);
    queue_request(FUNC_SAMPLE, 16'sd3, 3'd0, 18'sd0);

    // Full taps on both sides with extreme coefficients in the last slots.
    write_counts(4'd8, 4'd8, 1'b0);
    queue_request(FUNC_LOAD_B, -16'sd1, 3'd7, 18'sd131071);
    queue_request(FUNC_LOAD_A, 16'sd0, 3'd7, -18'sd131072);
    queue_request(FUNC_SAMPLE, SAMPLE_MAX, 3'd7, 18'sd0);
    queue_request(FUNC_SAMPLE, SAMPLE_MIN, 3'd0, 18'sd0);
    queue_request(FUNC_SAMPLE, 16'sd0, 3'd0, 18'sd0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin b_set = 4'd0;  a_set = 4'd15; end
        1: begin b_set = 4'd15; a_set = 4'd0;  end
        2: begin b_set = 4'd1;  a_set = 4'd8;  end
        3: begin b_set = 4'd8;  a_set = 4'd1;  end
        4: begin b_set = 4'd9;  a_set = 4'd8;  end
        default: begin
          b_set = CNT_REG_W'($urandom_range(0, 15));
          a_set = CNT_REG_W'($urandom_range(0, 15));
        end
      endcase
      write_counts(b_set, a_set, 1'b1);
      if (p == RANDOM_PHASES - 1) calm = 1'b1;

      for (int k = 0; k < MAX_TAPS; k++) begin
        queue_request(FUNC_LOAD_B, SAMPLE_W'($urandom), COEF_IDX_W'(k), pick_coef(8192));
      end
      for (int k = 0; k < MAX_TAPS; k++) begin
        queue_request(FUNC_LOAD_A, SAMPLE_W'($urandom), COEF_IDX_W'(k), pick_coef(2048));
      end
      for (int n = 0; n < MIXED_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
          queue_request(FUNC_SAMPLE, pick_sample(), COEF_IDX_W'($urandom),
                        COEF_W'($urandom));
        end else if (pick < 88) begin
          queue_request(FUNC_LOAD_B, SAMPLE_W'($urandom), COEF_IDX_W'($urandom),
                        pick_coef(8192));
        end else if (pick < 95) begin
          queue_request(FUNC_LOAD_A, SAMPLE_W'($urandom), COEF_IDX_W'($urandom),
                        pick_coef(2048));
        end else begin
          queue_request(FUNC_UNUSED, SAMPLE_W'($urandom), COEF_IDX_W'($urandom),
                        COEF_W'($urandom));
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (expected_responses.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, expected_responses.size());
      fail_count++;
    end

    $display("Run covered %0d filtered samples, %0d coefficient loads taken and %0d refused,",
             samples_filtered, loads_taken, loads_refused);
    $display("%0d requests with the unused code, across %0d tap count settings.",
             unused_requests, count_settings + 1);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/iirdf_pkg.sv
src/iirdf_ctrl.sv
src/iirdf_dp.sv
src/iir_direct_form_filter.sv
tb/iir_direct_form_filter_tb.sv
